[sv/mpe_pkg.sv]
// ----------------------------------------------------------------------------
// mpe_pkg: shared types and constants of the MBR partition entry encoder
// Word layouts of both channels, register indexes and CHS widths.
// ----------------------------------------------------------------------------
package mpe_pkg;

  // Field widths
  localparam int unsigned LBA_W   = 32;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned SPT_W   = 6;
  localparam int unsigned HEADS_W = 8;
  localparam int unsigned PCYL_W  = SPT_W + HEADS_W;   // sectors per cylinder
  localparam int unsigned CYL_W   = 10;                // cylinders 0..1023
  localparam int unsigned ADDR_W  = PCYL_W + CYL_W;    // clamped address
  localparam int unsigned TRK_W   = HEADS_W + CYL_W;   // track number

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPT   = 1'b0,
    CFG_HEADS = 1'b1
  } mpe_cfg_idx_t;

  // Register reset values
  localparam logic [SPT_W-1:0]   SPT_RST   = 6'd63;
  localparam logic [HEADS_W-1:0] HEADS_RST = 8'd255;

  // Input word
  typedef struct packed {
    logic [LBA_W-1:0]  start_lba;
    logic [LBA_W-1:0]  end_lba;
    logic [BYTE_W-1:0] system_id;
  } mpe_in_t;

  // Result word
  typedef struct packed {
    logic [BYTE_W-1:0] type_byte;
    logic [LBA_W-1:0]  first_sector;
    logic [LBA_W-1:0]  sector_count;
    logic [BYTE_W-1:0] start_head;
    logic [BYTE_W-1:0] begin_sector_byte;
    logic [BYTE_W-1:0] begin_cylinder_low;
    logic [BYTE_W-1:0] stop_head;
    logic [BYTE_W-1:0] end_sector_byte;
    logic [BYTE_W-1:0] end_cylinder_low;
  } mpe_out_t;

  // Fields that ride along the divider chain unchanged
  typedef struct packed {
    logic [BYTE_W-1:0] type_byte;
    logic [LBA_W-1:0]  first_sector;
    logic [LBA_W-1:0]  sector_count;
  } mpe_pass_t;

  // Side data of the head/cylinder chain: pass fields plus sector remainders
  typedef struct packed {
    mpe_pass_t        pass;
    logic [SPT_W-1:0] sec_b;
    logic [SPT_W-1:0] sec_e;
  } mpe_side2_t;

endpackage

[sv/mpe_front.sv]
// ----------------------------------------------------------------------------
// mpe_front: entry stage
// Clamps both addresses to the last sector of cylinder 1023 and forms the
// sector count; registers the result as the head of the divider chain.
// ----------------------------------------------------------------------------
module mpe_front import mpe_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              up_vld,
  input  mpe_in_t           up_data,
  input  logic [PCYL_W-1:0] per_cyl,
  output logic              dn_vld,
  output logic [ADDR_W-1:0] dn_addr_b,
  output logic [ADDR_W-1:0] dn_addr_e,
  output mpe_pass_t         dn_pass
);

  logic              vld_r;
  logic [ADDR_W-1:0] addr_b_r, addr_b_nxt;
  logic [ADDR_W-1:0] addr_e_r, addr_e_nxt;
  mpe_pass_t         pass_r, pass_nxt;
  logic [ADDR_W-1:0] limit;
  logic [ADDR_W-1:0] last_sec;

  // Clamp above the last addressable cylinder
  always_comb begin
    limit    = {per_cyl, {CYL_W{1'b0}}};
    last_sec = limit - {{(ADDR_W-1){1'b0}}, 1'b1};
    if (up_data.start_lba >= {{(LBA_W-ADDR_W){1'b0}}, limit}) begin
      addr_b_nxt = last_sec;
    end else begin
      addr_b_nxt = up_data.start_lba[ADDR_W-1:0];
    end
    if (up_data.end_lba >= {{(LBA_W-ADDR_W){1'b0}}, limit}) begin
      addr_e_nxt = last_sec;
    end else begin
      addr_e_nxt = up_data.end_lba[ADDR_W-1:0];
    end
    pass_nxt.type_byte    = up_data.system_id;
    pass_nxt.first_sector = up_data.start_lba;
    pass_nxt.sector_count = up_data.end_lba - up_data.start_lba + {{(LBA_W-1){1'b0}}, 1'b1};
  end

  // Advance valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= up_vld;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      addr_b_r <= addr_b_nxt;
      addr_e_r <= addr_e_nxt;
      pass_r   <= pass_nxt;
    end
  end

  assign dn_vld    = vld_r;
  assign dn_addr_b = addr_b_r;
  assign dn_addr_e = addr_e_r;
  assign dn_pass   = pass_r;

endmodule

[sv/mpe_div_cell.sv]
// ----------------------------------------------------------------------------
// mpe_div_cell: one restoring division step, two lanes
// Shifts one dividend bit into the partial remainder, subtracts the divisor
// when it fits and shifts the quotient bit in; side data rides along.
// ----------------------------------------------------------------------------
module mpe_div_cell #(
  parameter int unsigned NW = 24,
  parameter int unsigned DW = 6,
  parameter int unsigned SW = 72
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic [DW-1:0] divisor,
  input  logic          up_vld,
  input  logic [DW-1:0] up_rem_b,
  input  logic [NW-1:0] up_word_b,
  input  logic [DW-1:0] up_rem_e,
  input  logic [NW-1:0] up_word_e,
  input  logic [SW-1:0] up_side,
  output logic          dn_vld,
  output logic [DW-1:0] dn_rem_b,
  output logic [NW-1:0] dn_word_b,
  output logic [DW-1:0] dn_rem_e,
  output logic [NW-1:0] dn_word_e,
  output logic [SW-1:0] dn_side
);

  logic          vld_r;
  logic [DW-1:0] rem_b_r, rem_b_nxt;
  logic [NW-1:0] word_b_r, word_b_nxt;
  logic [DW-1:0] rem_e_r, rem_e_nxt;
  logic [NW-1:0] word_e_r, word_e_nxt;
  logic [SW-1:0] side_r;
  logic [DW:0]   trial_b, trial_e;
  logic [DW:0]   diff_b, diff_e;
  logic          fit_b, fit_e;

  // Trial subtract on both lanes
  always_comb begin
    trial_b    = {up_rem_b, up_word_b[NW-1]};
    trial_e    = {up_rem_e, up_word_e[NW-1]};
    diff_b     = trial_b - {1'b0, divisor};
    diff_e     = trial_e - {1'b0, divisor};
    fit_b      = (trial_b >= {1'b0, divisor});
    fit_e      = (trial_e >= {1'b0, divisor});
    rem_b_nxt  = fit_b ? diff_b[DW-1:0] : trial_b[DW-1:0];
    rem_e_nxt  = fit_e ? diff_e[DW-1:0] : trial_e[DW-1:0];
    word_b_nxt = {up_word_b[NW-2:0], fit_b};
    word_e_nxt = {up_word_e[NW-2:0], fit_e};
  end

  // Advance valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= up_vld;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      rem_b_r  <= rem_b_nxt;
      word_b_r <= word_b_nxt;
      rem_e_r  <= rem_e_nxt;
      word_e_r <= word_e_nxt;
      side_r   <= up_side;
    end
  end

  assign dn_vld    = vld_r;
  assign dn_rem_b  = rem_b_r;
  assign dn_word_b = word_b_r;
  assign dn_rem_e  = rem_e_r;
  assign dn_word_e = word_e_r;
  assign dn_side   = side_r;

endmodule

[sv/mbr_partition_entry_encoder.sv]
// ----------------------------------------------------------------------------
// mbr_partition_entry_encoder: MBR partition entry encoder
// Builds the fields of a 16-byte partition entry, with begin and end CHS.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : request word (start LBA, end LBA, system id), valid/ready.
//   out_* : entry fields (type, first sector, count, begin/end CHS).
//   cfg_* : write-only registers; index 0 sectors per track, index 1 heads.
//           A zero divisor acts as 1. Write only while the block is idle.
// Path: from acceptance to out_valid a word passes one clamp stage, 24
//   division cells by sectors per track, 10 cells by head count, and the
//   output register.
// Throughput: one word per cycle unless frozen (see Stall); the row of division
//   cells takes a new word every unfrozen cycle, each holding one word in flight.
// Reset: pipeline empties, registers return to 63 sectors and 255 heads.
// Stall: when out_valid waits on out_ready, the chain keeps moving as long
//   as its last cell is empty; it freezes, and in_ready drops, only when a
//   finished word reaches the last cell while the output is still held.
// ----------------------------------------------------------------------------
module mbr_partition_entry_encoder import mpe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mpe_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output mpe_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned PASS_W  = $bits(mpe_pass_t);
  localparam int unsigned SIDE2_W = $bits(mpe_side2_t);
  localparam int unsigned N1      = ADDR_W;   // sector division steps
  localparam int unsigned N2      = CYL_W;    // head division steps

  // Configuration
  logic [SPT_W-1:0]   spt_r, spt_nxt;
  logic [HEADS_W-1:0] heads_r, heads_nxt;
  logic [PCYL_W-1:0]  pcyl_r, pcyl_nxt;

  // Flow control
  logic     en;
  logic     last_vld;
  mpe_out_t out_r, out_nxt;
  logic     out_vld_r;

  // Chain by sectors per track
  logic              c1_vld    [0:N1];
  logic [SPT_W-1:0]  c1_rem_b  [0:N1];
  logic [ADDR_W-1:0] c1_word_b [0:N1];
  logic [SPT_W-1:0]  c1_rem_e  [0:N1];
  logic [ADDR_W-1:0] c1_word_e [0:N1];
  logic [PASS_W-1:0] c1_side   [0:N1];
  mpe_pass_t         front_pass;

  // Chain by head count
  logic               c2_vld    [0:N2];
  logic [HEADS_W-1:0] c2_rem_b  [0:N2];
  logic [CYL_W-1:0]   c2_word_b [0:N2];
  logic [HEADS_W-1:0] c2_rem_e  [0:N2];
  logic [CYL_W-1:0]   c2_word_e [0:N2];
  logic [SIDE2_W-1:0] c2_side   [0:N2];
  mpe_side2_t         side2_in, side2_out;
  logic [TRK_W-1:0]   trk_b, trk_e;
  logic [SPT_W-1:0]   sec_b1, sec_e1;

  // Decode register writes, zero divisor taken as 1
  always_comb begin
    spt_nxt   = spt_r;
    heads_nxt = heads_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_SPT: begin
          spt_nxt = (cfg_wdata[SPT_W-1:0] == '0) ? {{(SPT_W-1){1'b0}}, 1'b1}
                                                 : cfg_wdata[SPT_W-1:0];
        end
        CFG_HEADS: begin
          heads_nxt = (cfg_wdata[HEADS_W-1:0] == '0) ? {{(HEADS_W-1){1'b0}}, 1'b1}
                                                     : cfg_wdata[HEADS_W-1:0];
        end
        default: begin
          spt_nxt   = spt_r;
          heads_nxt = heads_r;
        end
      endcase
    end
    pcyl_nxt = PCYL_W'(spt_nxt) * PCYL_W'(heads_nxt);
  end

  // Hold configuration and sectors per cylinder
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spt_r   <= SPT_RST;
      heads_r <= HEADS_RST;
      pcyl_r  <= PCYL_W'(SPT_RST) * PCYL_W'(HEADS_RST);
    end else begin
      spt_r   <= spt_nxt;
      heads_r <= heads_nxt;
      pcyl_r  <= pcyl_nxt;
    end
  end

  // Freeze the chain only when a finished word meets a held output
  assign en       = !(out_vld_r && !out_ready && last_vld);
  assign in_ready = en;

  // Clamp and count stage
  mpe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .up_vld    (in_valid),
    .up_data   (in_data),
    .per_cyl   (pcyl_r),
    .dn_vld    (c1_vld[0]),
    .dn_addr_b (c1_word_b[0]),
    .dn_addr_e (c1_word_e[0]),
    .dn_pass   (front_pass)
  );

  assign c1_rem_b[0] = '0;
  assign c1_rem_e[0] = '0;
  assign c1_side[0]  = front_pass;

  // Sector division cells
  for (genvar i = 0; i < N1; i++) begin : g_c1
    mpe_div_cell #(
      .NW (ADDR_W),
      .DW (SPT_W),
      .SW (PASS_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .divisor   (spt_r),
      .up_vld    (c1_vld[i]),
      .up_rem_b  (c1_rem_b[i]),
      .up_word_b (c1_word_b[i]),
      .up_rem_e  (c1_rem_e[i]),
      .up_word_e (c1_word_e[i]),
      .up_side   (c1_side[i]),
      .dn_vld    (c1_vld[i+1]),
      .dn_rem_b  (c1_rem_b[i+1]),
      .dn_word_b (c1_word_b[i+1]),
      .dn_rem_e  (c1_rem_e[i+1]),
      .dn_word_e (c1_word_e[i+1]),
      .dn_side   (c1_side[i+1])
    );
  end

  // Track number is below heads * 1024: preload its upper bits as remainder
  always_comb begin
    trk_b          = c1_word_b[N1][TRK_W-1:0];
    trk_e          = c1_word_e[N1][TRK_W-1:0];
    side2_in.pass  = c1_side[N1];
    side2_in.sec_b = c1_rem_b[N1];
    side2_in.sec_e = c1_rem_e[N1];
  end

  assign c2_vld[0]    = c1_vld[N1];
  assign c2_rem_b[0]  = trk_b[TRK_W-1:CYL_W];
  assign c2_word_b[0] = trk_b[CYL_W-1:0];
  assign c2_rem_e[0]  = trk_e[TRK_W-1:CYL_W];
  assign c2_word_e[0] = trk_e[CYL_W-1:0];
  assign c2_side[0]   = side2_in;

  // Head division cells
  for (genvar j = 0; j < N2; j++) begin : g_c2
    mpe_div_cell #(
      .NW (CYL_W),
      .DW (HEADS_W),
      .SW (SIDE2_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .divisor   (heads_r),
      .up_vld    (c2_vld[j]),
      .up_rem_b  (c2_rem_b[j]),
      .up_word_b (c2_word_b[j]),
      .up_rem_e  (c2_rem_e[j]),
      .up_word_e (c2_word_e[j]),
      .up_side   (c2_side[j]),
      .dn_vld    (c2_vld[j+1]),
      .dn_rem_b  (c2_rem_b[j+1]),
      .dn_word_b (c2_word_b[j+1]),
      .dn_rem_e  (c2_rem_e[j+1]),
      .dn_word_e (c2_word_e[j+1]),
      .dn_side   (c2_side[j+1])
    );
  end

  assign last_vld = c2_vld[N2];

  // Assemble the entry fields
  always_comb begin
    side2_out = c2_side[N2];
    sec_b1    = side2_out.sec_b + {{(SPT_W-1){1'b0}}, 1'b1};
    sec_e1    = side2_out.sec_e + {{(SPT_W-1){1'b0}}, 1'b1};
    out_nxt.type_byte          = side2_out.pass.type_byte;
    out_nxt.first_sector       = side2_out.pass.first_sector;
    out_nxt.sector_count       = side2_out.pass.sector_count;
    out_nxt.start_head         = c2_rem_b[N2];
    out_nxt.begin_sector_byte  = {c2_word_b[N2][CYL_W-1:BYTE_W], sec_b1};
    out_nxt.begin_cylinder_low = c2_word_b[N2][BYTE_W-1:0];
    out_nxt.stop_head          = c2_rem_e[N2];
    out_nxt.end_sector_byte    = {c2_word_e[N2][CYL_W-1:BYTE_W], sec_e1};
    out_nxt.end_cylinder_low   = c2_word_e[N2][BYTE_W-1:0];
  end

  // Output register: load when empty or taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (!out_vld_r || out_ready) begin
      out_vld_r <= last_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld_r || out_ready) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

[verif/mbr_partition_entry_encoder_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mbr_partition_entry_encoder_tb: self-checking bench for the entry encoder
// Drives request words through the valid/ready input and predicts each
// partition entry (type, first sector, count, begin/end CHS) from the
// current geometry registers. Every result word is compared field by field.
// Directed corner cases come first, then random requests over several
// geometries and idle/stall patterns on both channels.
// ----------------------------------------------------------------------------
module mbr_partition_entry_encoder_tb;
  import mpe_pkg::*;

  localparam longint unsigned CYL_LAST    = 1023;
  localparam longint unsigned CYL_SPAN    = 1024;
  localparam longint unsigned CYL_HI_MASK = 'hC0;
  localparam int              DRAIN_TAIL  = 40;        // pipeline is 36 deep
  localparam int              TIMEOUT_NS  = 1_000_000;

  typedef struct packed {
    logic [7:0] head;
    logic [7:0] sec_byte;
    logic [7:0] cyl_low;
  } chs_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  mpe_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  mpe_out_t              out_data;
  logic                  cfg_we    = 1'b0;
  mpe_cfg_idx_t          cfg_idx   = CFG_SPT;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Geometry as the block should hold it
  logic [SPT_W-1:0]   spt_cfg   = SPT_RST;
  logic [HEADS_W-1:0] heads_cfg = HEADS_RST;

  mpe_out_t pending_entries[$];
  int       err_count = 0;
  int       gap_pct   = 0;
  int       stall_pct = 0;

  mbr_partition_entry_encoder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("FAIL");
    $finish;
  end

  // ------------------------------------------------------------------
  // Prediction
  // ------------------------------------------------------------------
  function automatic longint unsigned eff_spt();
    return (spt_cfg == 0) ? 1 : spt_cfg;
  endfunction

  function automatic longint unsigned eff_heads();
    return (heads_cfg == 0) ? 1 : heads_cfg;
  endfunction

  function automatic chs_t encode_chs(logic [31:0] lba);
    longint unsigned spt, hc, per_cyl, a, s, h, hi;
    chs_t c;
    spt     = eff_spt();
    hc      = eff_heads();
    per_cyl = spt * hc;
    a       = 64'(lba);
    // clamp to the last sector of cylinder 1023
    if (a / per_cyl > CYL_LAST) a = per_cyl * CYL_SPAN - 1;
    s  = a % spt + 1;
    a  = a / spt;
    h  = a % hc;
    a  = a / hc;
    hi = (a >> 2) & CYL_HI_MASK;
    s  = s | hi;
    c.head     = h[7:0];
    c.sec_byte = s[7:0];
    c.cyl_low  = a[7:0];
    return c;
  endfunction

  function automatic mpe_out_t predict_entry(mpe_in_t req);
    mpe_out_t e;
    chs_t     b, f;
    b = encode_chs(req.start_lba);
    f = encode_chs(req.end_lba);
    e.type_byte          = req.system_id;
    e.first_sector       = req.start_lba;
    e.sector_count       = req.end_lba - req.start_lba + 32'd1;
    e.start_head         = b.head;
    e.begin_sector_byte  = b.sec_byte;
    e.begin_cylinder_low = b.cyl_low;
    e.stop_head          = f.head;
    e.end_sector_byte    = f.sec_byte;
    e.end_cylinder_low   = f.cyl_low;
    return e;
  endfunction

  // ------------------------------------------------------------------
  // Checking
  // ------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  // Compare each accepted result word with the oldest pending entry
  always @(posedge clk) begin : result_check
    mpe_out_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_entries.size() == 0) begin
        report_mismatch("result word with no pending entry");
      end else begin
        want = pending_entries.pop_front();
        check_field("type_byte", out_data.type_byte, want.type_byte);
        check_field("first_sector", out_data.first_sector, want.first_sector);
        check_field("sector_count", out_data.sector_count, want.sector_count);
        check_field("start_head", out_data.start_head, want.start_head);
        check_field("begin_sector_byte", out_data.begin_sector_byte,
                    want.begin_sector_byte);
        check_field("begin_cylinder_low", out_data.begin_cylinder_low,
                    want.begin_cylinder_low);
        check_field("stop_head", out_data.stop_head, want.stop_head);
        check_field("end_sector_byte", out_data.end_sector_byte, want.end_sector_byte);
        check_field("end_cylinder_low", out_data.end_cylinder_low,
                    want.end_cylinder_low);
      end
    end
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // ------------------------------------------------------------------
  // Driving
  // ------------------------------------------------------------------
  // Send one request word; valid stays high on return so the next word
  // can follow back to back.
  task automatic send_request(mpe_in_t req);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_entries.push_back(predict_entry(req));
  endtask

  task automatic send_req(logic [31:0] s, logic [31:0] e, logic [7:0] id);
    mpe_in_t req;
    req.start_lba = s;
    req.end_lba   = e;
    req.system_id = id;
    send_request(req);
  endtask

  // Drop valid and hold until every pending entry has come back
  task automatic wait_drained(bit with_tail);
    in_valid <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk);
    if (with_tail) repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  // Write both geometry registers; call only while the block is idle
  task automatic cfg_set(logic [7:0] spt_data, logic [7:0] heads_data);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_SPT;
    cfg_wdata <= spt_data;
    @(posedge clk);
    spt_cfg    = spt_data[SPT_W-1:0];
    cfg_idx   <= CFG_HEADS;
    cfg_wdata <= heads_data;
    @(posedge clk);
    heads_cfg  = heads_data;
    cfg_we    <= 1'b0;
  endtask

  // ------------------------------------------------------------------
  // Random requests
  // ------------------------------------------------------------------
  function automatic logic [31:0] pick_lba();
    longint unsigned per_cyl, span;
    per_cyl = eff_spt() * eff_heads();
    span    = per_cyl * CYL_SPAN;
    case ($urandom_range(4))
      0:       return $urandom;
      1:       return 32'(span - 3 + $urandom_range(5));   // around the clamp edge
      2:       return $urandom_range(32'(span - 1));       // inside CHS range
      3:       return $urandom_range(32'(per_cyl * 3));    // first cylinders
      default: return $urandom_range(1) ? 32'hFFFF_FFFF - $urandom_range(7)
                                        : 32'($urandom_range(7));
    endcase
  endfunction

  task automatic send_random_request();
    logic [31:0] s, e;
    int          kind;
    longint unsigned per_cyl;
    per_cyl = eff_spt() * eff_heads();
    s       = pick_lba();
    kind    = $urandom_range(99);
    // mostly well-formed ranges, some unrelated ends, some reversed
    if (kind < 60)      e = s + $urandom_range(32'(per_cyl * 8));
    else if (kind < 85) e = pick_lba();
    else                e = s - $urandom_range(32'(per_cyl * 2 + 1));
    send_req(s, e, 8'($urandom_range(255)));
  endtask

  task automatic run_phase(logic [7:0] spt_data, logic [7:0] heads_data,
                           int gap, int stall, int n);
    cfg_set(spt_data, heads_data);
    gap_pct   = gap;
    stall_pct = stall;
    repeat (n) send_random_request();
    wait_drained(1);
  endtask

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------
  // Corner cases at the reset geometry (63 sectors, 255 heads)
  task automatic test_directed_default();
    logic [31:0] per_cyl, span;
    per_cyl   = 32'(eff_spt() * eff_heads());
    span      = per_cyl * 1024;
    gap_pct   = 0;
    stall_pct = 0;
    send_req(0, 0, 8'h00);                          // single-sector request
    send_req(0, 32'hFFFF_FFFF, 8'hFF);
    send_req(32'hFFFF_FFFF, 0, 8'h00);              // reversed, count wraps
    send_req(1000, 10, 8'h83);
    send_req(span - 1, span, 8'h07);                // last sector, then clamp
    send_req(span, 32'hFFFF_FFFF, 8'h0C);
    send_req(62, 63, 8'h83);                        // sector wraps to next head
    send_req(per_cyl - 1, per_cyl, 8'h83);          // head wraps to next cylinder
    send_req(per_cyl * 1023, span - 1, 8'h05);
    send_req(per_cyl * 256, per_cyl * 768 - 1, 8'hEF); // cylinder high bits
    send_req(32'hAAAA_AAAA, 32'h5555_5555, 8'hAA);
    send_req(32'h5555_5555, 32'hAAAA_AAAA, 8'h55);
    send_req(2048, 2048 + 1048575, 8'h83);
    wait_drained(1);
  endtask

  // Zero in either register acts as a divisor of one
  task automatic test_zero_divisor();
    cfg_set(8'd0, 8'd0);
    send_req(0, 0, 8'h00);
    send_req(1023, 1024, 8'h01);
    send_req(5, 4, 8'h02);
    wait_drained(0);
    cfg_set(8'd0, 8'd16);
    send_req(16 * 1024 - 1, 16 * 1024, 8'h0B);
    wait_drained(0);
    cfg_set(8'd32, 8'd0);
    send_req(32 * 1024 - 1, 32 * 1024, 8'h0C);
    wait_drained(1);
  endtask

  // Extremes of the geometry, no idling on either side
  task automatic test_geometry_extremes();
    run_phase(8'd1,  8'd1,   0, 0, 40);
    run_phase(8'd63, 8'd1,   0, 0, 40);
    run_phase(8'd1,  8'd255, 0, 0, 40);
    run_phase(8'd0,  8'd0,   0, 0, 30);
    run_phase(8'd63, 8'd255, 0, 0, 40);
  endtask

  // Sender gaps and receiver stalls
  task automatic test_idle_patterns();
    run_phase(8'd63, 8'd16,  82, 0,  60);
    run_phase(8'd32, 8'd64,  0,  82, 60);
    run_phase(8'd17, 8'd255, 29, 29, 60);
    run_phase(8'd63, 8'd255, 0,  0,  60);
  endtask

  // Pause the sender until every pending entry has come back
  task automatic test_drain_pause();
    cfg_set(8'd63, 8'd128);
    gap_pct   = 29;
    stall_pct = 29;
    repeat (3) begin
      repeat (15) send_random_request();
      wait_drained(0);
    end
    wait_drained(1);
  endtask

  // Random geometry, including write data with bits above the register
  task automatic test_random_geometry();
    int pcts[4] = '{0, 82, 29, 0};
    repeat (4) begin
      run_phase(8'($urandom_range(255)), 8'($urandom_range(255)),
                pcts[$urandom_range(3)], pcts[$urandom_range(3)], 15);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_default();
    test_zero_divisor();
    test_geometry_extremes();
    test_idle_patterns();
    test_drain_pause();
    test_random_geometry();
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
